### rtl/kss_pkg.sv
// Shared types, constants, keyword table and character helpers of the keyword scanner.
`timescale 1ns / 1ps
`default_nettype none

package kss_pkg;

    localparam int KW_NUM      = 65;
    localparam int KW_MAX_LEN  = 64;
    localparam int WIN_DEPTH   = KW_MAX_LEN - 1;
    localparam int KW_IDX_W    = 7;
    localparam int CAP_W       = 24;
    localparam int KW_BITS     = 8 * KW_MAX_LEN;

    localparam logic [CAP_W-1:0] CAP_RESET = 24'h80_0000;
    localparam logic [7:0]       SUBST_CHAR = 8'h3F;

    typedef logic [7:0]          t_char;
    typedef logic [KW_IDX_W-1:0] t_kw_idx;
    typedef logic [CAP_W-1:0]    t_cap;
    typedef logic [KW_BITS-1:0]  t_kw_text;

    // One queue entry: up to two characters and the end-of-scan mark.
    typedef struct packed {
        logic  last;
        logic  wide;
        logic  c0_vld;
        t_char c0;
        logic  c1_vld;
        t_char c1;
    } t_entry;

    // Keyword text, right aligned: the last character sits in bits [7:0].
    localparam t_kw_text KW_TEXT [KW_NUM] = '{
        t_kw_text'({"invoke-mimi", "katz"}),
        t_kw_text'("sekurlsa::logonpasswords"),
        t_kw_text'("sekurlsa::wdigest"),
        t_kw_text'("kerberos::ptt"),
        t_kw_text'("kerberos::golden"),
        t_kw_text'("kerberos::silver"),
        t_kw_text'("lsadump::sam"),
        t_kw_text'("lsadump::dcsync"),
        t_kw_text'("privilege::debug"),
        t_kw_text'("token::elevate"),
        t_kw_text'("invoke-shellcode"),
        t_kw_text'("invoke-reflectivepeinjection"),
        t_kw_text'("invoke-bloodhound"),
        t_kw_text'({"powers", "ploit"}),
        t_kw_text'({"power", "up"}),
        t_kw_text'({"power", "view"}),
        t_kw_text'({"sharp", "hound"}),
        t_kw_text'({"am", "sibypass"}),
        t_kw_text'({"am", "siutils"}),
        t_kw_text'({"am", "sicontext"}),
        t_kw_text'("[ref].assembly.gettype"),
        t_kw_text'({"system.management.automation.am", "si"}),
        t_kw_text'("virtualalloc"),
        t_kw_text'("createthread"),
        t_kw_text'("shellcode"),
        t_kw_text'({"meter", "preter"}),
        t_kw_text'({"cobalt", "strike"}),
        t_kw_text'("downloadstring("),
        t_kw_text'("downloaddata("),
        t_kw_text'("net.webclient"),
        t_kw_text'("wscript.shell"),
        t_kw_text'("eval(request"),
        t_kw_text'("eval(request.item"),
        t_kw_text'("execute(request("),
        t_kw_text'("eval request("),
        t_kw_text'("<%eval request"),
        t_kw_text'("response.write(eval("),
        t_kw_text'("gaborone"),
        t_kw_text'("pass="),
        t_kw_text'("javax.crypto.cipher"),
        t_kw_text'("aesencode"),
        t_kw_text'("createaescipher"),
        t_kw_text'({"behin", "der"}),
        t_kw_text'("e45e329feb5d925b"),
        t_kw_text'("javax.crypto.spec.secretkeyspec"),
        t_kw_text'("aes/ecb/pkcs5padding"),
        t_kw_text'("classloader.defineclass"),
        t_kw_text'("assembly.load(convert.frombase64string"),
        t_kw_text'({"ant", "sword"}),
        t_kw_text'("ant_"),
        t_kw_text'("asoutputstream"),
        t_kw_text'({"@eval(base64", "_decode("}),
        t_kw_text'({"assert(base64", "_decode("}),
        t_kw_text'("system.reflection.assembly.load"),
        t_kw_text'("processbuilder("),
        t_kw_text'("runtime.getruntime().exec("),
        t_kw_text'("unsafe.eval("),
        t_kw_text'("frombase64string"),
        t_kw_text'({"thread", "_start(system.delegate"}),
        t_kw_text'("httppostedfile"),
        t_kw_text'({"file_put", "_contents("}),
        t_kw_text'("passthru("),
        t_kw_text'("system("),
        t_kw_text'({"proc", "_open("}),
        t_kw_text'({"pcntl", "_exec("})
    };

    // Number of characters in a keyword: nonzero bytes counted from the low end.
    function automatic int kw_len(input t_kw_text txt);
        int   n;
        logic run;
        n   = 0;
        run = 1'b1;
        for (int i = 0; i < KW_MAX_LEN; i++) begin
            if (run && (txt[8*i +: 8] != 8'h00)) begin
                n++;
            end else begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

    function automatic t_char lower_ascii(input t_char c);
        if ((c >= 8'h41) && (c <= 8'h5A)) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    // UTF-16LE unit to one character: ASCII range lowercased, the rest substituted.
    function automatic t_char unit_char(input t_char lo, input t_char hi);
        if ((hi == 8'h00) && !lo[7]) begin
            return lower_ascii(lo);
        end
        return SUBST_CHAR;
    endfunction

endpackage

`default_nettype wire

### rtl/keyword_stream_scanner.sv
// Top level of the keyword stream scanner: front end, entry queue and match engine.
`timescale 1ns / 1ps
`default_nettype none

// Scans the content bytes of one scan for any of 65 fixed keywords. Each input
// transaction carries at most one byte (has_byte) and may close the scan
// (scan_end); only the closing transaction yields a result: detected, the lowest
// index of the keywords seen and whether the content was read as UTF-16LE (byte 1
// of the content zero). Bytes beyond max_content_bytes are ignored; write the cap
// only while the block is idle. Throughput is one input transaction per cycle
// while the queue is not full: the front end decodes a byte per cycle into a
// small queue, and the match engine compares one character per cycle against all
// keywords in parallel unless a finished result is held up by a blocked output.
// The one exception is the second byte of a narrow scan, which releases two
// characters that the match engine takes in two steps; the queue absorbs it. A
// result passes from the queue through the compare register and the final flag
// register into the output register, behind any entries still queued ahead of its
// closing transaction, and the output register lets input continue while it waits.
module keyword_stream_scanner #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire kss_pkg::t_cap     i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire kss_pkg::t_char    i_data_byte,
    input  wire logic              i_has_byte,
    input  wire logic              i_scan_end,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_detected,
    output kss_pkg::t_kw_idx       o_keyword_index,
    output logic                   o_wide_content
);
    import kss_pkg::*;

    logic   w_push;
    t_entry w_entry;
    logic   w_q_full;
    logic   w_q_valid;
    t_entry w_q_head;
    logic   w_q_pop;

    // Front end: cap, pair assembly and lowercasing.
    kss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_has_byte  (i_has_byte),
        .i_scan_end  (i_scan_end),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_entry     (w_entry)
    );

    // Decouple decode from matching so either side can stall alone.
    kss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_head  (w_q_head)
    );

    // Match engine and result transaction.
    kss_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_head        (w_q_head),
        .o_q_pop         (w_q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_detected      (o_detected),
        .o_keyword_index (o_keyword_index),
        .o_wide_content  (o_wide_content)
    );

endmodule

`default_nettype wire

### rtl/kss_front.sv
// Front end: accepts input transactions, applies the byte cap, decodes narrow or wide content.
`timescale 1ns / 1ps
`default_nettype none

module kss_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire kss_pkg::t_cap    i_cfg_data,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire kss_pkg::t_char   i_data_byte,
    input  wire logic             i_has_byte,
    input  wire logic             i_scan_end,
    input  wire logic             i_q_full,
    output logic                  o_push,
    output kss_pkg::t_entry       o_entry
);
    import kss_pkg::*;

    t_cap  r_cap;
    t_cap  r_count, n_count;
    t_char r_held, n_held;
    logic  r_wide, n_wide;
    logic  r_pair, n_pair;
    logic  w_take;
    t_entry w_entry;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign o_entry = w_entry;
    assign w_take  = i_has_byte && (r_count < r_cap);

    always_comb begin
        n_count = r_count;
        n_held  = r_held;
        n_wide  = r_wide;
        n_pair  = r_pair;
        w_entry = '0;
        if (w_take) begin
            priority if (r_count == '0) begin
                n_held = i_data_byte;
            end else if (r_count == t_cap'(1)) begin
                if (i_data_byte == 8'h00) begin
                    n_wide         = 1'b1;
                    n_pair         = 1'b0;
                    w_entry.c0_vld = 1'b1;
                    w_entry.c0     = unit_char(r_held, i_data_byte);
                end else begin
                    w_entry.c0_vld = 1'b1;
                    w_entry.c0     = lower_ascii(r_held);
                    w_entry.c1_vld = 1'b1;
                    w_entry.c1     = lower_ascii(i_data_byte);
                end
            end else if (r_wide) begin
                if (r_pair) begin
                    n_pair         = 1'b0;
                    w_entry.c0_vld = 1'b1;
                    w_entry.c0     = unit_char(r_held, i_data_byte);
                end else begin
                    n_held = i_data_byte;
                    n_pair = 1'b1;
                end
            end else begin
                w_entry.c0_vld = 1'b1;
                w_entry.c0     = lower_ascii(i_data_byte);
            end
            n_count = r_count + t_cap'(1);
        end
        if (i_scan_end) begin
            // A single byte scan is narrow: emit the held byte now.
            if (n_count == t_cap'(1)) begin
                w_entry.c0_vld = 1'b1;
                w_entry.c0     = lower_ascii(n_held);
            end
            w_entry.last = 1'b1;
            w_entry.wide = n_wide;
            n_count      = '0;
            n_held       = '0;
            n_wide       = 1'b0;
            n_pair       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_count <= '0;
            r_held  <= '0;
            r_wide  <= 1'b0;
            r_pair  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (o_push) begin
                r_count <= n_count;
                r_held  <= n_held;
                r_wide  <= n_wide;
                r_pair  <= n_pair;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/kss_queue.sv
// Short FIFO of decoded entries between the front end and the match engine.
`timescale 1ns / 1ps
`default_nettype none

module kss_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire kss_pkg::t_entry  i_entry,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output kss_pkg::t_entry       o_head
);
    import kss_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/kss_back.sv
// Match engine: character window, parallel keyword compare, hit flags and result register.
`timescale 1ns / 1ps
`default_nettype none

module kss_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire kss_pkg::t_entry  i_q_head,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic                  o_detected,
    output kss_pkg::t_kw_idx      o_keyword_index,
    output logic                  o_wide_content
);
    import kss_pkg::*;

    // Window: r_win[0] is the newest character.
    t_char              r_win [WIN_DEPTH];
    t_char              w_cand [KW_MAX_LEN];
    wire [KW_NUM-1:0]   w_hit;

    logic               r_sub;
    logic               w_cur_vld;
    t_char              w_cur_ch;
    logic               w_pop_now;
    logic               w_step;
    logic               w_end_now;
    logic               w_advance;

    logic               r_s1_valid;
    logic               r_s1_end;
    logic               r_s1_wide;
    logic [KW_NUM-1:0]  r_s1_hits;

    logic [KW_NUM-1:0]  r_flags;
    logic [KW_NUM-1:0]  r_final;
    logic               r_fin_valid;
    logic               r_fin_wide;

    logic               r_out_valid;
    logic               r_out_det;
    t_kw_idx            r_out_idx;
    logic               r_out_wide;
    t_kw_idx            w_first_idx;

    // Hold the whole pipe only when a result is ready and the output is blocked.
    assign w_advance = !(r_fin_valid && r_out_valid && !i_ready);

    // An entry with two characters takes two steps; the second pops it.
    always_comb begin
        if (r_sub) begin
            w_cur_vld = i_q_head.c1_vld;
            w_cur_ch  = i_q_head.c1;
            w_pop_now = 1'b1;
        end else begin
            w_cur_vld = i_q_head.c0_vld;
            w_cur_ch  = i_q_head.c0;
            w_pop_now = !i_q_head.c1_vld;
        end
    end

    assign w_step    = w_advance && i_q_valid;
    assign o_q_pop   = w_step && w_pop_now;
    assign w_end_now = w_pop_now && i_q_head.last;

    always_comb begin
        w_cand[0] = w_cur_ch;
        for (int j = 1; j < KW_MAX_LEN; j++) begin
            w_cand[j] = r_win[j-1];
        end
    end

    for (genvar k = 0; k < KW_NUM; k++) begin : g_kw
        localparam int LEN = kw_len(KW_TEXT[k]);
        logic w_match;
        always_comb begin
            w_match = w_cur_vld && (LEN > 0);
            for (int j = 0; j < LEN; j++) begin
                if (w_cand[j] != KW_TEXT[k][8*j +: 8]) begin
                    w_match = 1'b0;
                end
            end
        end
        assign w_hit[k] = w_match;
    end

    always_comb begin
        w_first_idx = '0;
        for (int k = KW_NUM - 1; k >= 0; k--) begin
            if (r_final[k]) begin
                w_first_idx = t_kw_idx'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub       <= 1'b0;
            r_win       <= '{default: '0};
            r_s1_valid  <= 1'b0;
            r_s1_end    <= 1'b0;
            r_s1_wide   <= 1'b0;
            r_s1_hits   <= '0;
            r_flags     <= '0;
            r_final     <= '0;
            r_fin_valid <= 1'b0;
            r_fin_wide  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_det   <= 1'b0;
            r_out_idx   <= '0;
            r_out_wide  <= 1'b0;
        end else begin
            if (w_step) begin
                r_sub <= !w_pop_now;
                if (w_end_now) begin
                    r_win <= '{default: '0};
                end else if (w_cur_vld) begin
                    for (int i = WIN_DEPTH - 1; i > 0; i--) begin
                        r_win[i] <= r_win[i-1];
                    end
                    r_win[0] <= w_cur_ch;
                end
            end
            if (w_advance) begin
                r_s1_valid <= i_q_valid;
                r_s1_end   <= i_q_valid && w_end_now;
                r_s1_wide  <= i_q_head.wide;
                r_s1_hits  <= i_q_valid ? w_hit : '0;

                r_fin_valid <= r_s1_valid && r_s1_end;
                r_fin_wide  <= r_s1_wide;
                if (r_s1_valid) begin
                    if (r_s1_end) begin
                        r_final <= r_flags | r_s1_hits;
                        r_flags <= '0;
                    end else begin
                        r_flags <= r_flags | r_s1_hits;
                    end
                end
            end
            if (r_fin_valid && w_advance) begin
                r_out_valid <= 1'b1;
                r_out_det   <= |r_final;
                r_out_idx   <= w_first_idx;
                r_out_wide  <= r_fin_wide;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_detected      = r_out_det;
    assign o_keyword_index = r_out_idx;
    assign o_wide_content  = r_out_wide;

endmodule

`default_nettype wire
